@@ hw/rtl/pdg_pkg.sv @@
// Shared constants, command and result types for the pyramid downsample block.
package pdg_pkg;

    localparam int MaxCoarseWidth  = 1024;
    localparam int MaxCoarseHeight = 1024;

    localparam int CxW      = $clog2(MaxCoarseWidth);
    localparam int CyW      = $clog2(MaxCoarseHeight);
    localparam int FineCntW = 11;
    localparam int FineWW   = 12;
    localparam int CoarseWW = 11;
    localparam int CfgIdxW  = 2;
    localparam int PixW     = 16;
    localparam int PairW    = 17;
    localparam int ValW     = 18;
    localparam int GradW    = 19;
    localparam int PosW     = 10;

    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int OutDepth   = 8;
    localparam int OPtrW      = $clog2(OutDepth);

    localparam logic [CfgIdxW-1:0] CFG_FINE_WIDTH    = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_COARSE_WIDTH  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_COARSE_HEIGHT = 2'd2;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_PAIR  = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    typedef struct packed {
        logic [FineWW-1:0]   fine_width;
        logic [CoarseWW-1:0] width;
        logic [CoarseWW-1:0] height;
    } t_geom;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CxW-1:0]   cx;
        logic [CxW-1:0]   left_idx;
        logic [CxW-1:0]   right_idx;
        logic [CyW-1:0]   cy;
        logic [PairW-1:0] pair;
        logic             emit_first;
        logic             emit_second;
        logic             grad_ok;
        logic             single_col;
    } t_cmd;

    typedef struct packed {
        logic [ValW-1:0]         value;
        logic signed [GradW-1:0] grad_h;
        logic signed [GradW-1:0] grad_v;
        logic                    grad_valid;
        logic [PosW-1:0]         column;
        logic [PosW-1:0]         row;
        logic                    last;
    } t_result;

endpackage

@@ hw/rtl/pdg_front.sv @@
// Front end: position counters, horizontal pair sum and command classification.
module pdg_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pdg_pkg::t_geom         i_geom,
    input  logic                   i_valid,
    input  logic [pdg_pkg::PixW-1:0] i_pixel_value,
    input  logic                   i_frame_start,
    output logic                   o_ready,
    input  logic                   i_q_ready,
    output logic                   o_push,
    output pdg_pkg::t_cmd          o_cmd
);
    import pdg_pkg::*;

    logic [FineCntW-1:0] r_fcol, n_fcol, r_frow, n_frow, fx, fy;
    logic [PixW-1:0]     r_hsum;
    logic                accept, col_wrap, in_range;
    logic [CxW-1:0]      cx;
    logic [CyW-1:0]      cy;

    assign o_ready = i_q_ready;
    assign accept  = i_valid && i_q_ready;

    always_comb begin
        fx       = i_frame_start ? '0 : r_fcol;
        fy       = i_frame_start ? '0 : r_frow;
        col_wrap = (({1'b0, fx} + 12'd1) >= i_geom.fine_width) || (fx == '1);
        n_fcol   = col_wrap ? '0 : fx + 1'b1;
        n_frow   = col_wrap ? fy + 1'b1 : fy;
        in_range = ({1'b0, fx} < {i_geom.width, 1'b0}) &&
                   ({1'b0, fy} < {i_geom.height, 1'b0});
        cx       = CxW'(fx >> 1);
        cy       = CyW'(fy >> 1);
    end

    always_comb begin
        o_cmd.kind        = !fx[0] ? CMD_READ : (fy[0] ? CMD_EVENT : CMD_PAIR);
        o_cmd.cx          = cx;
        o_cmd.left_idx    = (cx == '0) ? CxW'(i_geom.width - 11'd1) : cx - 1'b1;
        o_cmd.right_idx   = ((12'(cx) + 12'd1) >= 12'(i_geom.width)) ? '0 : cx + 1'b1;
        o_cmd.cy          = cy;
        o_cmd.pair        = PairW'(r_hsum) + PairW'(i_pixel_value);
        o_cmd.emit_first  = (cy != '0);
        o_cmd.emit_second = ((12'(cy) + 12'd1) == 12'(i_geom.height));
        o_cmd.grad_ok     = (cy >= CyW'(2));
        o_cmd.single_col  = (i_geom.width == 11'd1);
    end

    assign o_push = accept && in_range && (fx[0] || fy[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcol <= '0;
            r_frow <= '0;
            r_hsum <= '0;
        end else if (accept) begin
            r_fcol <= n_fcol;
            r_frow <= n_frow;
            if (in_range && !fx[0]) begin
                r_hsum <= i_pixel_value;
            end
        end
    end

endmodule

@@ hw/rtl/pdg_queue.sv @@
// Short command queue between the front end and the back end.
module pdg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pdg_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output pdg_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import pdg_pkg::*;

    t_cmd             r_mem [QueueDepth];
    logic [QPtrW-1:0] r_wptr, r_rptr;
    logic [QPtrW:0]   r_count;

    assign o_ready = (r_count != (QPtrW+1)'(QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ hw/rtl/pdg_back.sv @@
// Back end: line memories, block sums, gradients and the result buffer.
module pdg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pdg_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output pdg_pkg::t_result o_result
);
    import pdg_pkg::*;

    logic [PairW-1:0] r_pair_mem  [MaxCoarseWidth];
    logic [ValW-1:0]  r_above_mem [MaxCoarseWidth];
    logic [ValW-1:0]  r_cur_mem   [MaxCoarseWidth];

    logic [PairW-1:0] r_ps_rd;
    logic [ValW-1:0]  r_abv_rd, r_cur_rd;

    logic             room, is_read, is_pair, is_event;
    logic             fetch, primed_ok, r_primed;
    logic [CxW-1:0]   r_primed_cx;
    logic [ValW-1:0]  v;
    logic [CxW-1:0]   abv_addr, cur_addr;

    logic             r_s1_valid;
    logic [ValW-1:0]  r_s1_v, r_s1_center, r_s1_above;
    logic [CxW-1:0]   r_s1_cx;
    logic [CyW-1:0]   r_s1_cy;
    logic             r_s1_first, r_s1_second, r_s1_grad_ok, r_s1_single;

    logic [ValW-1:0]  right;
    t_result          res_a, res_b, slot0;
    logic             push_a, push_b, out_pop;
    logic [1:0]       n_pushes;

    t_result          r_ofifo [OutDepth];
    logic [OPtrW-1:0] r_wptr, r_rptr;
    logic [OPtrW:0]   r_ocount;

    // An event whose operands were not read ahead by the preceding command reads them first.
    assign primed_ok = r_primed && (r_primed_cx == i_cmd.cx);
    assign fetch     = i_cmd_valid && (i_cmd.kind == CMD_EVENT) && !primed_ok;

    assign room = ({1'b0, r_ocount} + (r_s1_valid ? 5'd2 : 5'd0)) <= 5'(OutDepth - 2);
    assign o_pop    = i_cmd_valid && ((i_cmd.kind != CMD_EVENT) || (room && primed_ok));
    assign is_read  = o_pop && (i_cmd.kind == CMD_READ);
    assign is_pair  = o_pop && (i_cmd.kind == CMD_PAIR);
    assign is_event = o_pop && (i_cmd.kind == CMD_EVENT);

    assign v        = ValW'(r_ps_rd) + ValW'(i_cmd.pair);
    assign abv_addr = is_event ? i_cmd.left_idx : i_cmd.cx;
    assign cur_addr = is_event ? i_cmd.right_idx : i_cmd.cx;

    always_ff @(posedge i_clk) begin
        if (is_pair) begin
            r_pair_mem[i_cmd.cx] <= i_cmd.pair;
        end
        if (is_read || fetch) begin
            r_ps_rd <= r_pair_mem[i_cmd.cx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_event) begin
            r_above_mem[i_cmd.cx] <= r_cur_rd;
        end
        if (is_read || is_event || fetch) begin
            r_abv_rd <= r_above_mem[abv_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_event) begin
            r_cur_mem[i_cmd.cx] <= v;
        end
        if (is_read || is_event || fetch) begin
            r_cur_rd <= r_cur_mem[cur_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read || fetch) begin
            r_primed_cx <= i_cmd.cx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_event) begin
            r_s1_v       <= v;
            r_s1_center  <= r_cur_rd;
            r_s1_above   <= r_abv_rd;
            r_s1_cx      <= i_cmd.cx;
            r_s1_cy      <= i_cmd.cy;
            r_s1_first   <= i_cmd.emit_first;
            r_s1_second  <= i_cmd.emit_second;
            r_s1_grad_ok <= i_cmd.grad_ok;
            r_s1_single  <= i_cmd.single_col;
        end
    end

    always_comb begin
        right = r_s1_single ? r_s1_v : r_cur_rd;

        res_a.value      = r_s1_center;
        res_a.grad_h     = r_s1_grad_ok ? (GradW'(right) - GradW'(r_abv_rd)) : '0;
        res_a.grad_v     = r_s1_grad_ok ? (GradW'(r_s1_v) - GradW'(r_s1_above)) : '0;
        res_a.grad_valid = r_s1_grad_ok;
        res_a.column     = PosW'(r_s1_cx);
        res_a.row        = PosW'(r_s1_cy - 1'b1);
        res_a.last       = !r_s1_second;

        res_b.value      = r_s1_v;
        res_b.grad_h     = '0;
        res_b.grad_v     = '0;
        res_b.grad_valid = 1'b0;
        res_b.column     = PosW'(r_s1_cx);
        res_b.row        = PosW'(r_s1_cy);
        res_b.last       = 1'b1;

        push_a   = r_s1_valid && r_s1_first;
        push_b   = r_s1_valid && r_s1_second;
        slot0    = push_a ? res_a : res_b;
        n_pushes = {1'b0, push_a} + {1'b0, push_b};
    end

    assign o_valid  = (r_ocount != '0);
    assign o_result = r_ofifo[r_rptr];
    assign out_pop  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push_a || push_b) begin
            r_ofifo[r_wptr] <= slot0;
        end
        if (push_a && push_b) begin
            r_ofifo[r_wptr + 1'b1] <= res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_primed   <= 1'b0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_ocount   <= '0;
        end else begin
            r_s1_valid <= is_event;
            if (is_read || fetch) begin
                r_primed <= 1'b1;
            end else if (o_pop) begin
                r_primed <= 1'b0;
            end
            r_wptr     <= r_wptr + OPtrW'(n_pushes);
            if (out_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_ocount <= r_ocount + (OPtrW+1)'(n_pushes) - (OPtrW+1)'(out_pop);
        end
    end

endmodule

@@ hw/rtl/pyramid_downsample_with_gradients.sv @@
// Top level of the 2x2 pyramid downsample with central-difference gradients.
// The block takes one fine pixel word per clock while its command queue has room, and returns
// coarse pixel words one coarse row late; each coarse pixel of the last row gives two words,
// so the output side delivers up to one word per clock. A word passes through the command
// queue, the event stage register and the result buffer before it is presented. Each completed
// block is handled as two successive commands against single-read-port line memories (a read
// ahead on the even fine column, then the sum, write back and neighbor reads on the odd one).
// A four-entry command queue and an eight-word result buffer let the input and output
// sides stall independently. The line memories need no clearing after reset.
module pyramid_downsample_with_gradients (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pdg_pkg::CfgIdxW-1:0]         i_cfg_idx,
    input  logic [pdg_pkg::FineWW-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [pdg_pkg::PixW-1:0]            i_pixel_value,
    input  logic                                i_frame_start,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [pdg_pkg::ValW-1:0]            o_coarse_value,
    output logic signed [pdg_pkg::GradW-1:0]    o_grad_horizontal,
    output logic signed [pdg_pkg::GradW-1:0]    o_grad_vertical,
    output logic                                o_grad_valid,
    output logic [pdg_pkg::PosW-1:0]            o_column,
    output logic [pdg_pkg::PosW-1:0]            o_row,
    output logic                                o_last_of_run
);
    import pdg_pkg::*;

    logic [FineWW-1:0]   r_fine_width;
    logic [CoarseWW-1:0] r_coarse_width, r_coarse_height;
    t_geom               geom;

    logic                q_ready, q_valid, push, pop;
    t_cmd                push_cmd, head_cmd;
    t_result             result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_width    <= 12'd1280;
            r_coarse_width  <= 11'd640;
            r_coarse_height <= 11'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FINE_WIDTH:    r_fine_width    <= i_cfg_data;
                CFG_COARSE_WIDTH:  r_coarse_width  <= i_cfg_data[CoarseWW-1:0];
                CFG_COARSE_HEIGHT: r_coarse_height <= i_cfg_data[CoarseWW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        geom.fine_width = r_fine_width;
        geom.width  = (int'(r_coarse_width) > MaxCoarseWidth) ?
                      CoarseWW'(MaxCoarseWidth) : r_coarse_width;
        geom.height = (int'(r_coarse_height) > MaxCoarseHeight) ?
                      CoarseWW'(MaxCoarseHeight) : r_coarse_height;
    end

    pdg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_geom        (geom),
        .i_valid       (i_valid),
        .i_pixel_value (i_pixel_value),
        .i_frame_start (i_frame_start),
        .o_ready       (o_ready),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pdg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    pdg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (result)
    );

    assign o_coarse_value    = result.value;
    assign o_grad_horizontal = result.grad_h;
    assign o_grad_vertical   = result.grad_v;
    assign o_grad_valid      = result.grad_valid;
    assign o_column          = result.column;
    assign o_row             = result.row;
    assign o_last_of_run     = result.last;

endmodule

@@ hw/rtl/pdg_checker.sv @@
// Port-level checker for the pyramid downsample block and its bind statement.
module pdg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic [pdg_pkg::ValW-1:0]         o_coarse_value,
    input logic signed [pdg_pkg::GradW-1:0] o_grad_horizontal,
    input logic signed [pdg_pkg::GradW-1:0] o_grad_vertical,
    input logic                             o_grad_valid,
    input logic [pdg_pkg::PosW-1:0]         o_column,
    input logic [pdg_pkg::PosW-1:0]         o_row,
    input logic                             o_last_of_run
);
    import pdg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_coarse_value) &&
        $stable(o_grad_horizontal) && $stable(o_grad_vertical) &&
        $stable(o_column) && $stable(o_row) && $stable(o_last_of_run))
        else $error("Output word changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output word present right after reset.");

    a_grad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_grad_valid |-> o_grad_horizontal == '0 && o_grad_vertical == '0)
        else $error("Nonzero gradient on a word without gradients.");

    a_grad_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_grad_valid |-> o_row != '0)
        else $error("Gradient reported on the first coarse row.");

endmodule

bind pyramid_downsample_with_gradients pdg_checker u_pdg_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the 2x2 pyramid downsample with gradient outputs.
module testbench;
    import pdg_pkg::*;

    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 500;
    localparam int STALL_LIMIT   = 4000;

    typedef struct packed {
        logic [PixW-1:0] pixel;
        logic            first;
    } t_fine_word;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = '0;
    logic [FineWW-1:0]   cfg_data = '0;

    logic                pix_valid = 1'b0;
    logic [PixW-1:0]     pix_value = '0;
    logic                pix_first = 1'b0;
    logic                dut_in_ready;

    logic                recv_ready = 1'b0;
    logic                rx_ready;
    logic                res_valid;
    logic [ValW-1:0]     res_value;
    logic signed [GradW-1:0] res_grad_h;
    logic signed [GradW-1:0] res_grad_v;
    logic                res_grad_valid;
    logic [PosW-1:0]     res_column;
    logic [PosW-1:0]     res_row;
    logic                res_last;

    t_fine_word  pending_pixels[$];
    t_result     awaited_results[$];
    int unsigned queued_items = 0;
    int unsigned mismatches = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    logic        hold_start = 1'b0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    // Model of the block state, kept in step with accepted pixels.
    int unsigned      geom_fine_width = 1280;
    int unsigned      geom_coarse_width = 640;
    int unsigned      geom_coarse_height = 480;
    int unsigned      fine_col = 0;
    int unsigned      fine_row = 0;
    logic [PairW-1:0] held_pair = '0;
    logic [PairW-1:0] pair_line [MaxCoarseWidth];
    logic [ValW-1:0]  above_line [MaxCoarseWidth];
    logic [ValW-1:0]  current_line [MaxCoarseWidth];

    pyramid_downsample_with_gradients dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_valid           (pix_valid),
        .o_ready           (dut_in_ready),
        .i_pixel_value     (pix_value),
        .i_frame_start     (pix_first),
        .o_valid           (res_valid),
        .i_ready           (rx_ready),
        .o_coarse_value    (res_value),
        .o_grad_horizontal (res_grad_h),
        .o_grad_vertical   (res_grad_v),
        .o_grad_valid      (res_grad_valid),
        .o_column          (res_column),
        .o_row             (res_row),
        .o_last_of_run     (res_last)
    );

    assign rx_ready = recv_ready && (hold_left == 0);

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void predict_pixel(logic [PixW-1:0] pix, logic first);
        int unsigned      fx, fy, w, h, cx, cy, row_up, left_idx, right_idx;
        logic [PairW-1:0] pair;
        logic [ValW-1:0]  block_sum, center, above, left_val, right_val;
        logic             grads_on;
        t_result          res;
        t_result          made[$];
        if (first) begin
            fine_col = 0;
            fine_row = 0;
        end
        fx = fine_col;
        fy = fine_row;
        if (fx + 1 >= geom_fine_width || fx >= 2047) begin
            fine_col = 0;
            fine_row = (fy + 1) % 2048;
        end else begin
            fine_col = fx + 1;
        end
        w = (geom_coarse_width > MaxCoarseWidth) ? MaxCoarseWidth : geom_coarse_width;
        h = (geom_coarse_height > MaxCoarseHeight) ? MaxCoarseHeight : geom_coarse_height;
        if (fx >= 2 * w || fy >= 2 * h) return;
        cx = fx / 2;
        cy = fy / 2;
        if (fx % 2 == 0) begin
            held_pair = PairW'(pix);
            return;
        end
        pair = held_pair + pix;
        if (fy % 2 == 0) begin
            pair_line[cx] = pair;
            return;
        end
        block_sum = pair_line[cx] + pair;
        center = current_line[cx];
        above = above_line[cx];
        left_idx = (cx == 0) ? w - 1 : cx - 1;
        left_val = above_line[left_idx];
        above_line[cx] = center;
        current_line[cx] = block_sum;
        right_idx = (cx + 1 >= w) ? 0 : cx + 1;
        right_val = current_line[right_idx];
        if (cy > 0) begin
            row_up = cy - 1;
            grads_on = (row_up >= 1) && (row_up + 2 <= h);
            res = '0;
            res.value = center;
            res.grad_valid = grads_on;
            if (grads_on) begin
                res.grad_h = GradW'({1'b0, right_val} - {1'b0, left_val});
                res.grad_v = GradW'({1'b0, block_sum} - {1'b0, above});
            end
            res.column = PosW'(cx);
            res.row = PosW'(row_up);
            made.push_back(res);
        end
        if (cy + 1 == h) begin
            res = '0;
            res.value = block_sum;
            res.column = PosW'(cx);
            res.row = PosW'(cy);
            made.push_back(res);
        end
        if (made.size() != 0) made[made.size() - 1].last = 1'b1;
        foreach (made[k]) awaited_results.push_back(made[k]);
    endfunction

    function automatic void compare_field(string name, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [PixW-1:0] draw_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PixW'($urandom);
        endcase
    endfunction

    function automatic int unsigned fine_row_length(int unsigned fw);
        if (fw <= 1) return 1;
        if (fw > 2048) return 2048;
        return fw;
    endfunction

    task automatic queue_pixel(logic [PixW-1:0] pixel, logic first);
        t_fine_word word;
        word.pixel = pixel;
        word.first = first;
        pending_pixels.push_back(word);
        queued_items++;
    endtask

    task automatic queue_frame(int unsigned row_len, int unsigned rows);
        for (int unsigned n = 0; n < row_len * rows; n++) begin
            queue_pixel(draw_pixel(), n == 0);
        end
    endtask

    task automatic wait_until_quiet();
        while (pending_pixels.size() != 0 || pix_valid || awaited_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_geometry(int unsigned fw, int unsigned cw, int unsigned ch);
        wait_until_quiet();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_FINE_WIDTH;
        cfg_data <= FineWW'(fw);
        geom_fine_width = fw % 4096;
        @(posedge clk);
        cfg_idx <= CFG_COARSE_WIDTH;
        cfg_data <= FineWW'(cw);
        geom_coarse_width = cw % 2048;
        @(posedge clk);
        cfg_idx <= CFG_COARSE_HEIGHT;
        cfg_data <= FineWW'(ch);
        geom_coarse_height = ch % 2048;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk) begin : driver
        t_fine_word word;
        if (!rst_n) begin
            pix_valid <= 1'b0;
            send_wait <= 0;
        end else begin
            if (pix_valid && dut_in_ready) predict_pixel(pix_value, pix_first);
            if (!pix_valid || dut_in_ready) begin
                if (pending_pixels.size() == 0) begin
                    pix_valid <= 1'b0;
                end else if (send_wait != 0) begin
                    send_wait <= send_wait - 1;
                    pix_valid <= 1'b0;
                end else begin
                    word = pending_pixels.pop_front();
                    pix_valid <= 1'b1;
                    pix_value <= word.pixel;
                    pix_first <= word.first;
                    send_wait <= send_calm ? 0 : $urandom_range(0, 15);
                end
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_result     want;
        int unsigned pause;
        if (!rst_n) begin
            recv_ready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (res_valid && rx_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: word with nothing expected, value %0d column %0d row %0d",
                             $time, res_value, res_column, res_row);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("coarse_value", want.value, res_value);
                    compare_field("grad_horizontal", want.grad_h, res_grad_h);
                    compare_field("grad_vertical", want.grad_v, res_grad_v);
                    compare_field("grad_valid", want.grad_valid, res_grad_valid);
                    compare_field("column", want.column, res_column);
                    compare_field("row", want.row, res_row);
                    compare_field("last_of_run", want.last, res_last);
                end
                pause = recv_calm ? 0 : $urandom_range(0, 15);
                recv_wait <= pause;
                recv_ready <= (pause == 0);
            end else if (recv_wait != 0) begin
                recv_wait <= recv_wait - 1;
                recv_ready <= (recv_wait == 1);
            end else begin
                recv_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((pix_valid && dut_in_ready) || (res_valid && rx_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned fw, cw, ch, row_len, frame_len, phase, covered;
        covered = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // One full small frame: a saturated block, an ignored column and an ignored row.
        program_geometry(5, 2, 2);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 5; c++) begin
                queue_pixel((c < 2) ? '1 : ((c < 4) ? '0 : draw_pixel()), r == 0 && c == 0);
            end
        end
        queue_pixel(draw_pixel(), 1'b0);
        covered = 2;

        // Zero geometry ignores everything; oversized geometry is clamped.
        program_geometry(2, 0, 0);
        queue_pixel(draw_pixel(), 1'b1);
        queue_pixel(draw_pixel(), 1'b0);
        program_geometry(4095, 2047, 2047);
        queue_pixel(draw_pixel(), 1'b1);
        queue_pixel(draw_pixel(), 1'b0);

        phase = 0;
        queued_items = 0;
        while (queued_items < RANDOM_ITEMS) begin
            if (phase == 0) begin
                cw = 8;
                ch = 4;
                fw = 16;
            end else begin
                cw = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                ch = (cw > 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
                // Narrow input rows leave coarse columns stale, so only after they were filled.
                if (cw <= covered && $urandom_range(0, 3) == 0) begin
                    fw = $urandom_range(0, 2 * cw + 3);
                end else begin
                    fw = 2 * cw + $urandom_range(0, 3);
                end
            end
            program_geometry(fw, cw, ch);
            send_calm = (phase == 0) || ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            row_len = fine_row_length(fw);
            frame_len = row_len * 2 * ch;
            if ($urandom_range(0, 2) == 0) begin
                queue_pixel(draw_pixel(), 1'b1);
                repeat ($urandom_range(0, frame_len - 1)) begin
                    queue_pixel(draw_pixel(), $urandom_range(0, 15) == 0);
                end
            end
            repeat ($urandom_range(1, 3)) queue_frame(row_len, 2 * ch);
            if (2 * cw <= row_len && ch >= 2 && cw > covered) covered = cw;
            repeat ($urandom_range(0, 2 * row_len)) queue_pixel(draw_pixel(), 1'b0);
            if (phase == 0) begin
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            phase++;
        end

        wait_until_quiet();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/pdg_pkg.sv
hw/rtl/pdg_front.sv
hw/rtl/pdg_queue.sv
hw/rtl/pdg_back.sv
hw/rtl/pyramid_downsample_with_gradients.sv
hw/rtl/pdg_checker.sv
bench/testbench.sv
